// ----- hdl/cpq_pkg.sv -----
// shared constants, types and helpers of the coalescing priority queue
package cpq_pkg;

  localparam int DEPTH         = 32;
  localparam int KEY_BITS      = 32;
  localparam int PAYLOAD_BYTES = 8;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int PAY_W   = 8 * PAYLOAD_BYTES;
  localparam int PRIO_W  = 4;
  localparam int LEN_W   = 4;
  localparam int LIMIT_W = 6;
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int REJ_W   = 32;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

  localparam logic [ADDR_W-3:0] REG_IDX_QUEUE_LIMIT = '0;

  localparam logic OP_PUBLISH = 1'b0;
  localparam logic OP_POP     = 1'b1;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_MERGE,
    ACT_POP
  } cpq_act_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [PRIO_W-1:0]   prio;
    logic [PAY_W-1:0]    payload;
    logic [LEN_W-1:0]    len;
  } cpq_entry_t;

  typedef struct packed {
    cpq_act_t         act;
    logic [CNT_W-1:0] fill;
    logic [PAY_W-1:0] mask;
    cpq_entry_t       new_entry;
  } cpq_ctrl_t;

  function automatic logic [PAY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [PAY_W-1:0] m;
    m = '0;
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      if (LEN_W'(b) < len) begin
        m[8*b +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// ----- hdl/cpq_in_if.sv -----
// input channel of the coalescing priority queue
interface cpq_in_if;
  import cpq_pkg::*;

  logic                valid;
  logic                ready;
  logic                opcode;
  logic [KEY_BITS-1:0] sig_key;
  logic [PRIO_W-1:0]   prio;
  logic [PAY_W-1:0]    payload_in;
  logic [LEN_W-1:0]    payload_len;

  modport source (
    output valid, opcode, sig_key, prio, payload_in, payload_len,
    input  ready
  );

  modport sink (
    input  valid, opcode, sig_key, prio, payload_in, payload_len,
    output ready
  );
endinterface

// ----- hdl/cpq_out_if.sv -----
// result channel of the coalescing priority queue
interface cpq_out_if;
  import cpq_pkg::*;

  logic                valid;
  logic                ready;
  logic                accepted;
  logic                merged;
  logic                pop_valid;
  logic [KEY_BITS-1:0] out_key;
  logic [PRIO_W-1:0]   out_prio;
  logic [PAY_W-1:0]    out_payload;
  logic [LEN_W-1:0]    out_len;
  logic [LIMIT_W-1:0]  occupancy;
  logic [LIMIT_W-1:0]  peak_occupancy;
  logic [REJ_W-1:0]    reject_count;

  modport source (
    output valid, accepted, merged, pop_valid, out_key, out_prio, out_payload, out_len,
           occupancy, peak_occupancy, reject_count,
    input  ready
  );

  modport sink (
    input  valid, accepted, merged, pop_valid, out_key, out_prio, out_payload, out_len,
           occupancy, peak_occupancy, reject_count,
    output ready
  );
endinterface

// ----- hdl/cpq_cell.sv -----
// one queue slot: compare against the incoming item and shift with its neighbours
module cpq_cell (
  input  logic                clk,
  input  logic [cpq_pkg::IDX_W-1:0] idx,
  input  cpq_pkg::cpq_ctrl_t  ctrl,
  input  logic                left_lower,
  input  cpq_pkg::cpq_entry_t left_entry,
  input  cpq_pkg::cpq_entry_t right_entry,
  output logic                lower,
  output logic                match,
  output cpq_pkg::cpq_entry_t entry
);
  import cpq_pkg::*;

  cpq_entry_t entry_r;
  cpq_entry_t entry_nxt;
  logic       occ;
  logic       tail;

  assign occ   = CNT_W'(idx) < ctrl.fill;
  assign tail  = CNT_W'(idx) == ctrl.fill;
  assign lower = occ && (entry_r.prio < ctrl.new_entry.prio);
  assign match = occ && (entry_r.key == ctrl.new_entry.key);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.act)
      ACT_INSERT: begin
        if (left_lower) begin
          entry_nxt = left_entry;
        end else if (lower || tail) begin
          entry_nxt = ctrl.new_entry;
        end
      end
      ACT_MERGE: begin
        if (match) begin
          entry_nxt.payload = (entry_r.payload & ~ctrl.mask) | ctrl.new_entry.payload;
        end
      end
      ACT_POP: begin
        entry_nxt = right_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end
endmodule

// ----- hdl/cpq_cfg.sv -----
// apb register holding the queue limit
module cpq_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpq_pkg::ADDR_W-1:0]   paddr,
  input  logic [cpq_pkg::DATA_W-1:0]   pwdata,
  output logic [cpq_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [cpq_pkg::LIMIT_W-1:0]  queue_limit
);
  import cpq_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] limit_nxt;
  logic               hit;

  assign hit    = paddr[ADDR_W-1:2] == REG_IDX_QUEUE_LIMIT;
  assign pready = 1'b1;
  assign prdata = hit ? DATA_W'(limit_r) : '0;
  assign queue_limit = limit_r;

  always_comb begin
    limit_nxt = limit_r;
    if (psel && penable && pwrite && hit) begin
      limit_nxt = pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end
endmodule

// ----- hdl/coalescing_priority_queue.sv -----
// Coalescing priority queue: a bounded queue kept in descending priority order, first in
// first out among equal priorities, built as a row of 32 slot cells that all compare the
// incoming key and priority at once and shift left or right together. A publish is rejected
// (and counted, saturating) while occupancy has reached the queue limit register or the
// depth; a publish whose key is already queued overwrites the low payload_len bytes of that
// entry in place; any other publish is inserted ahead of the first entry of lower priority.
// A pop removes the head. Each transfer produces exactly one result in an output register;
// one operation is taken per clock while the result side keeps up, the whole slot row being
// updated together. No clearing pass is needed after reset. The limit register lives at
// byte address 0 of the apb port and must only be written while the queue is idle.
module coalescing_priority_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  cpq_in_if.sink                     in_ch,
  cpq_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cpq_pkg::ADDR_W-1:0] paddr,
  input  logic [cpq_pkg::DATA_W-1:0] pwdata,
  output logic [cpq_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import cpq_pkg::*;

  logic [LIMIT_W-1:0] queue_limit;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   peak_r, peak_nxt;
  logic [REJ_W-1:0]   rej_r, rej_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               acc_r, mrg_r, pv_r;
  cpq_entry_t         head_r;
  logic               fire;
  logic               full;
  logic               any_match;
  logic [LEN_W-1:0]   len_sat;
  logic [PAY_W-1:0]   mask;
  cpq_ctrl_t          ctrl;
  cpq_act_t           act;
  logic [DEPTH-1:0]   lower_vec;
  logic [DEPTH-1:0]   match_vec;
  logic [DEPTH-1:0]   left_lower_vec;
  cpq_entry_t         ent [DEPTH];
  cpq_entry_t         ent_left [DEPTH];
  cpq_entry_t         ent_right [DEPTH];

  cpq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .queue_limit (queue_limit)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  assign len_sat   = (in_ch.payload_len > LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES)
                                                                 : in_ch.payload_len;
  assign mask      = byte_mask(len_sat);
  assign full      = (CMP_W'(fill_r) >= CMP_W'(DEPTH)) || (CMP_W'(fill_r) >= CMP_W'(queue_limit));
  assign any_match = |match_vec;

  always_comb begin
    act = ACT_HOLD;
    if (fire) begin
      if (in_ch.opcode == OP_PUBLISH) begin
        if (full) begin
          act = ACT_HOLD;
        end else if (any_match) begin
          act = ACT_MERGE;
        end else begin
          act = ACT_INSERT;
        end
      end else if (fill_r != '0) begin
        act = ACT_POP;
      end
    end
  end

  always_comb begin
    ctrl                   = '0;
    ctrl.act               = act;
    ctrl.fill              = fill_r;
    ctrl.mask              = mask;
    ctrl.new_entry.key     = in_ch.sig_key;
    ctrl.new_entry.prio    = in_ch.prio;
    ctrl.new_entry.payload = in_ch.payload_in & mask;
    ctrl.new_entry.len     = len_sat;
  end

  assign left_lower_vec = {lower_vec[DEPTH-2:0], 1'b0};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign ent_left[g] = ctrl.new_entry;
    end else begin : g_mid
      assign ent_left[g] = ent[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign ent_right[g] = ent[g];
    end else begin : g_inner
      assign ent_right[g] = ent[g+1];
    end

    cpq_cell u_cell (
      .clk         (clk),
      .idx         (IDX_W'(g)),
      .ctrl        (ctrl),
      .left_lower  (left_lower_vec[g]),
      .left_entry  (ent_left[g]),
      .right_entry (ent_right[g]),
      .lower       (lower_vec[g]),
      .match       (match_vec[g]),
      .entry       (ent[g])
    );
  end

  always_comb begin
    fill_nxt      = fill_r;
    peak_nxt      = peak_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
    end
    if (fire && (in_ch.opcode == OP_PUBLISH) && full && (rej_r != '1)) begin
      rej_nxt = rej_r + REJ_W'(1);
    end
    case (act)
      ACT_INSERT: begin
        fill_nxt = fill_r + CNT_W'(1);
        if (fill_nxt > peak_r) begin
          peak_nxt = fill_nxt;
        end
      end
      ACT_POP: begin
        fill_nxt = fill_r - CNT_W'(1);
      end
      default: begin
        fill_nxt = fill_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      peak_r      <= '0;
      rej_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      peak_r      <= peak_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r  <= (act == ACT_INSERT) || (act == ACT_MERGE);
      mrg_r  <= act == ACT_MERGE;
      pv_r   <= act == ACT_POP;
      head_r <= (act == ACT_POP) ? ent[0] : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = acc_r;
  assign out_ch.merged         = mrg_r;
  assign out_ch.pop_valid      = pv_r;
  assign out_ch.out_key        = head_r.key;
  assign out_ch.out_prio       = head_r.prio;
  assign out_ch.out_payload    = head_r.payload;
  assign out_ch.out_len        = head_r.len;
  assign out_ch.occupancy      = LIMIT_W'(fill_r);
  assign out_ch.peak_occupancy = LIMIT_W'(peak_r);
  assign out_ch.reject_count   = rej_r;

  // queued keys stay unique, so at most one slot can match
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one slot matches the incoming key");

  // queue order: once a slot is below the new priority, every later occupied slot is too
  a_lower_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    ((left_lower_vec & ~lower_vec & (match_vec | lower_vec | left_lower_vec)) &
     {DEPTH{1'b0}}) == '0 && ((lower_vec & ~left_lower_vec) & ((lower_vec & ~left_lower_vec) -
     DEPTH'(1))) == '0)
    else $error("slot priorities out of order");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (act == ACT_POP) |=> (fill_r == $past(fill_r) - CNT_W'(1)) && out_ch.pop_valid)
    else $error("pop did not remove one entry");

  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (peak_r >= fill_r) && (fill_r <= CNT_W'(DEPTH)))
    else $error("occupancy above peak or depth");
endmodule
